FILE: src/gclw_pkg.sv
// Shared constants and types for the grid cell line walk block.
// No dependencies; imported by grid_cell_line_walk_top.
`timescale 1ns / 1ps

package gclw_pkg;

    localparam int MAX_STEPS  = 64;
    localparam int CELL_SHIFT = 23;
    localparam int FRAC_BITS  = 16;

    localparam int TO_FRAC = CELL_SHIFT - FRAC_BITS;
    localparam int CELL_W  = 32 - CELL_SHIFT;
    // walking index: cell range plus headroom for the step limit
    localparam int MAP_W   = CELL_W + 8;
    localparam int CNT_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int PART_W  = FRAC_BITS + 1;

    localparam logic [31:0] ONE_UNIT   = 32'(1) << FRAC_BITS;
    localparam logic [31:0] FLAT_SLOPE = 32'(256) * ONE_UNIT;
    localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REL,
        ST_NUDGE,
        ST_DIFF,
        ST_DINIT,
        ST_DRUN,
        ST_DDONE,
        ST_MUL,
        ST_ADD,
        ST_WALK
    } state_t;

endpackage

FILE: src/grid_cell_line_walk_top.sv
// Grid cell line walk: emits the grid cells a 16.16 segment passes through.
// Depends on gclw_pkg for constants and the sequencer state type.
`timescale 1ns / 1ps

// Sequence: after the input transfer, ST_REL, ST_NUDGE, ST_DIFF, then per axis
//   ST_DINIT, ST_DRUN (32 divide iterations, skipped if the slope saturates),
//   ST_DDONE (also skipped if the axis does not move), ST_MUL, ST_ADD; then ST_WALK.
// Throughput: one segment at a time; a segment of N cells (N <= MAX_STEPS) holds
//   the input off until its last cell is loaded; the walk loads one cell per
//   cycle while the output register is empty or being drained.
// Reset: aresetn synchronous active low; clears the sequencer, the output valid
//   and all configuration registers to zero.
module grid_cell_line_walk_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input segment, fields from bit 0: start_x, start_y, end_x, end_y
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [127:0]                    s_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gclw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    // result cell, tdata fields from bit 0: cell_x, cell_y (4 zero pad bits)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,
    // tuser fields from bit 0: in_map
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);
    import gclw_pkg::*;

    // configuration
    logic [31:0] origin_x_reg, origin_y_reg;
    logic [9:0]  grid_width_reg, grid_height_reg;

    state_t state_reg, state_next;

    // segment coordinates, origin relative after ST_REL
    logic [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [31:0] dx_reg, dy_reg;
    logic [31:0] xstep_reg, ystep_reg;
    logic [31:0] xicpt_reg, yicpt_reg;
    logic [31:0] prod_reg;
    logic        axis_reg;       // 0: x-axis setup (ystep), 1: y-axis setup (xstep)

    // shared divider
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;        // dividend bits shift out, quotient bits shift in
    logic [31:0] den_reg;
    logic        neg_reg, sat_reg;
    logic [4:0]  div_cnt_reg;

    // walker
    logic [MAP_W-1:0] mapx_reg, mapy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic [9:0]       cell_x_reg, cell_y_reg;
    logic             in_map_reg, last_reg;

    // ------------------------------------------------------------------
    // Cell indices and step directions, all from registered coordinates
    // ------------------------------------------------------------------
    logic signed [CELL_W-1:0] xt1, yt1, xt2, yt2;
    logic x_fwd, x_back, y_fwd, y_back;

    assign xt1 = $signed(x1_reg[31:CELL_SHIFT]);
    assign yt1 = $signed(y1_reg[31:CELL_SHIFT]);
    assign xt2 = $signed(x2_reg[31:CELL_SHIFT]);
    assign yt2 = $signed(y2_reg[31:CELL_SHIFT]);
    assign x_fwd  = xt2 > xt1;
    assign x_back = xt2 < xt1;
    assign y_fwd  = yt2 > yt1;
    assign y_back = yt2 < yt1;

    // ------------------------------------------------------------------
    // Divider setup: numerator and divisor magnitude for the current axis
    // ------------------------------------------------------------------
    logic [31:0] div_num, div_oth, div_nmag, div_den;
    logic        div_flat, div_sat;

    assign div_num  = axis_reg ? dx_reg : dy_reg;
    assign div_oth  = axis_reg ? dy_reg : dx_reg;
    assign div_flat = axis_reg ? !(y_fwd || y_back) : !(x_fwd || x_back);
    assign div_nmag = div_num[31] ? (32'd0 - div_num) : div_num;
    assign div_den  = div_oth[31] ? (32'd0 - div_oth) : div_oth;
    // quotient would not fit: saturate (a zero divisor lands here too)
    assign div_sat  = (div_nmag >> 14) >= div_den;

    // one restoring step
    logic [32:0] div_shift, div_trial;
    assign div_shift = {rem_reg[31:0], quo_reg[31]};
    assign div_trial = div_shift - {1'b0, den_reg};

    logic [31:0] div_result;
    always_comb begin
        if (sat_reg) begin
            div_result = neg_reg ? SAT_NEG : SAT_POS;
        end else begin
            div_result = neg_reg ? (32'd0 - quo_reg) : quo_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: partial offset times slope, 16.16
    // ------------------------------------------------------------------
    logic [PART_W-1:0] partial;
    logic [FRAC_BITS-1:0] frac_sel;
    logic fwd_sel, back_sel;
    logic [31:0] mul_step;
    logic signed [PART_W+32:0] mul_full;

    assign frac_sel = axis_reg ? y1_reg[TO_FRAC+FRAC_BITS-1:TO_FRAC]
                               : x1_reg[TO_FRAC+FRAC_BITS-1:TO_FRAC];
    assign fwd_sel  = axis_reg ? y_fwd  : x_fwd;
    assign back_sel = axis_reg ? y_back : x_back;
    assign mul_step = axis_reg ? xstep_reg : ystep_reg;

    always_comb begin
        if (fwd_sel) begin
            partial = PART_W'(ONE_UNIT) - {1'b0, frac_sel};
        end else if (back_sel) begin
            partial = {1'b0, frac_sel};
        end else begin
            partial = PART_W'(ONE_UNIT);
        end
    end

    assign mul_full = $signed({1'b0, partial}) * $signed(mul_step);

    // start point in 16.16 cell-fraction units (arithmetic shift by TO_FRAC)
    logic [31:0] x1_frac, y1_frac;
    assign x1_frac = {{TO_FRAC{x1_reg[31]}}, x1_reg[31:TO_FRAC]};
    assign y1_frac = {{TO_FRAC{y1_reg[31]}}, y1_reg[31:TO_FRAC]};

    // ------------------------------------------------------------------
    // Walker: current cell, end test, map test, intercept matches
    // ------------------------------------------------------------------
    logic at_end, in_grid, y_hit, x_hit, item_last, emit;
    logic [31:0] mapx_ext, mapy_ext;

    assign mapx_ext = {{(32-MAP_W){mapx_reg[MAP_W-1]}}, mapx_reg};
    assign mapy_ext = {{(32-MAP_W){mapy_reg[MAP_W-1]}}, mapy_reg};
    assign at_end = (mapx_reg == MAP_W'(xt2)) && (mapy_reg == MAP_W'(yt2));
    assign in_grid = !mapx_reg[MAP_W-1] && !mapy_reg[MAP_W-1] &&
                     (mapx_reg < {{(MAP_W-10){1'b0}}, grid_width_reg}) &&
                     (mapy_reg < {{(MAP_W-10){1'b0}}, grid_height_reg});
    assign y_hit = {{16{yicpt_reg[31]}}, yicpt_reg[31:16]} == mapy_ext;
    assign x_hit = {{16{xicpt_reg[31]}}, xicpt_reg[31:16]} == mapx_ext;
    assign item_last = at_end || (cnt_reg == CNT_W'(MAX_STEPS - 1));
    // load a cell whenever the output register is empty or being drained
    assign emit = (state_reg == ST_WALK) && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_REL;
                end
            end
            ST_REL:   state_next = ST_NUDGE;
            ST_NUDGE: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_DINIT;
            ST_DINIT: begin
                if (div_flat) begin
                    state_next = ST_MUL;
                end else if (div_sat) begin
                    state_next = ST_DDONE;
                end else begin
                    state_next = ST_DRUN;
                end
            end
            ST_DRUN: begin
                if (div_cnt_reg == 5'd0) begin
                    state_next = ST_DDONE;
                end
            end
            ST_DDONE: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = axis_reg ? ST_WALK : ST_DINIT;
            ST_WALK: begin
                if (emit && item_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x1_reg <= s_tdata[31:0];
                    y1_reg <= s_tdata[63:32];
                    x2_reg <= s_tdata[95:64];
                    y2_reg <= s_tdata[127:96];
                end
            end
            ST_REL: begin
                x1_reg <= x1_reg - origin_x_reg;
                y1_reg <= y1_reg - origin_y_reg;
                x2_reg <= x2_reg - origin_x_reg;
                y2_reg <= y2_reg - origin_y_reg;
            end
            ST_NUDGE: begin
                // start exactly on a cell border: push it one unit inward
                if (x1_reg[CELL_SHIFT-1:0] == '0) begin
                    x1_reg <= x1_reg + ONE_UNIT;
                end
                if (y1_reg[CELL_SHIFT-1:0] == '0) begin
                    y1_reg <= y1_reg + ONE_UNIT;
                end
                axis_reg <= 1'b0;
            end
            ST_DIFF: begin
                dx_reg <= x2_reg - x1_reg;
                dy_reg <= y2_reg - y1_reg;
            end
            ST_DINIT: begin
                rem_reg     <= {17'd0, div_nmag[31:16]};
                quo_reg     <= {div_nmag[15:0], 16'd0};
                den_reg     <= div_den;
                neg_reg     <= div_num[31];
                sat_reg     <= div_sat;
                div_cnt_reg <= 5'd31;
                if (div_flat) begin
                    if (axis_reg) begin
                        xstep_reg <= FLAT_SLOPE;
                    end else begin
                        ystep_reg <= FLAT_SLOPE;
                    end
                end
            end
            ST_DRUN: begin
                if (!div_trial[32]) begin
                    rem_reg <= div_trial;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= div_shift;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            ST_DDONE: begin
                if (axis_reg) begin
                    xstep_reg <= div_result;
                end else begin
                    ystep_reg <= div_result;
                end
            end
            ST_MUL: begin
                prod_reg <= mul_full[FRAC_BITS+31:FRAC_BITS];
            end
            ST_ADD: begin
                if (axis_reg) begin
                    xicpt_reg <= x1_frac + prod_reg;
                    mapx_reg  <= MAP_W'(xt1);
                    mapy_reg  <= MAP_W'(yt1);
                    cnt_reg   <= '0;
                end else begin
                    yicpt_reg <= y1_frac + prod_reg;
                    axis_reg  <= 1'b1;
                end
            end
            ST_WALK: begin
                if (emit) begin
                    cell_x_reg <= mapx_reg[9:0];
                    cell_y_reg <= mapy_reg[9:0];
                    in_map_reg <= in_grid;
                    last_reg   <= item_last;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    // advance along whichever intercept lines up (y first on a tie); else repeat the cell
                    if (y_hit) begin
                        yicpt_reg <= yicpt_reg + ystep_reg;
                        if (x_fwd) begin
                            mapx_reg <= mapx_reg + MAP_W'(1);
                        end else if (x_back) begin
                            mapx_reg <= mapx_reg - MAP_W'(1);
                        end
                    end else if (x_hit) begin
                        xicpt_reg <= xicpt_reg + xstep_reg;
                        if (y_fwd) begin
                            mapy_reg <= mapy_reg + MAP_W'(1);
                        end else if (y_back) begin
                            mapy_reg <= mapy_reg - MAP_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output valid: set on load, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers, always ready
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[9:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, cell_y_reg, cell_x_reg};
    assign m_tuser  = in_map_reg;
    assign m_tlast  = last_reg;

endmodule
